FILE: hdl/trigger_object_multiplicity_deta_unit_assert.svh
// assertion macros for the trigger object multiplicity unit
// used by the top level; depends on nothing else
`ifndef TRIGGER_OBJECT_MULTIPLICITY_DETA_UNIT_ASSERT_SVH
`define TRIGGER_OBJECT_MULTIPLICITY_DETA_UNIT_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define TOMD_ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tomd: invariant violated");

// consequence that must hold in the cycle after the antecedent
`define TOMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tomd: next-cycle check failed");

`endif

FILE: hdl/tomd_pkg.sv
// shared types and constants of the trigger object multiplicity unit
// used by the interfaces, the register block, the eta store and the top level
`default_nettype none

package tomd_pkg;

  // field widths
  localparam int unsigned PT_W     = 16;
  localparam int unsigned ETA_W    = 11;
  localparam int unsigned ETAMAX_W = 10;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DETA_W   = 11;

  // store depth default
  localparam int unsigned MAX_OBJECTS_DEF = 16;

  // count saturation and smallest count that can hold a pair
  localparam logic [CNT_W-1:0] CNT_SAT      = 5'd31;
  localparam logic [CNT_W-1:0] PAIR_MIN_CNT = 5'd2;

  // register port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // register indexes (word address)
  typedef enum logic [2:0] {
    REG_PT_MIN     = 3'd0,
    REG_ETA_MAX    = 3'd1,
    REG_MIN_COUNT  = 3'd2,
    REG_DETA_MAX   = 3'd3,
    REG_PAIR_CHECK = 3'd4
  } reg_idx_e;

  // reset values
  localparam logic [PT_W-1:0]     PT_MIN_RST    = 16'd0;
  localparam logic [ETAMAX_W-1:0] ETA_MAX_RST   = 10'd1000;
  localparam logic [CNT_W-1:0]    MIN_COUNT_RST = 5'd1;
  localparam logic [DETA_W-1:0]   DETA_MAX_RST  = 11'd0;

  // configuration handed from the register block
  typedef struct packed {
    logic [PT_W-1:0]     pt_min;
    logic [ETAMAX_W-1:0] eta_max;
    logic [CNT_W-1:0]    min_count;
    logic [DETA_W-1:0]   deta_max;
    logic                pair_check_enable;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/tomd_if.sv
// valid/ready stream interfaces for object items and event results
// depends on tomd_pkg
`default_nettype none

// object item stream
interface tomd_in_if;
  import tomd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    has_object;
  logic [PT_W-1:0]         obj_pt;
  logic signed [ETA_W-1:0] obj_eta;
  logic                    event_last;

  modport source (output valid, has_object, obj_pt, obj_eta, event_last, input ready);
  modport sink   (input valid, has_object, obj_pt, obj_eta, event_last, output ready);
endinterface

// event result stream
interface tomd_out_if;
  import tomd_pkg::*;

  logic             valid;
  logic             ready;
  logic             fired;
  logic [CNT_W-1:0] selected_count;
  logic             stored_overflow;

  modport source (output valid, fired, selected_count, stored_overflow, input ready);
  modport sink   (input valid, fired, selected_count, stored_overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/tomd_cfg_regs.sv
// apb register block holding the selection and pair thresholds
// depends on tomd_pkg
`default_nettype none

module tomd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tomd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tomd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tomd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output tomd_pkg::cfg_t                      cfg_o
);
  import tomd_pkg::*;

  tomd_pkg::cfg_t cfg_q;
  logic           wr_en;
  reg_idx_e       idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pt_min            <= PT_MIN_RST;
      cfg_q.eta_max           <= ETA_MAX_RST;
      cfg_q.min_count         <= MIN_COUNT_RST;
      cfg_q.deta_max          <= DETA_MAX_RST;
      cfg_q.pair_check_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PT_MIN:     cfg_q.pt_min            <= pwdata[PT_W-1:0];
        REG_ETA_MAX:    cfg_q.eta_max           <= pwdata[ETAMAX_W-1:0];
        REG_MIN_COUNT:  cfg_q.min_count         <= pwdata[CNT_W-1:0];
        REG_DETA_MAX:   cfg_q.deta_max          <= pwdata[DETA_W-1:0];
        REG_PAIR_CHECK: cfg_q.pair_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PT_MIN:     prdata[PT_W-1:0]     = cfg_q.pt_min;
      REG_ETA_MAX:    prdata[ETAMAX_W-1:0] = cfg_q.eta_max;
      REG_MIN_COUNT:  prdata[CNT_W-1:0]    = cfg_q.min_count;
      REG_DETA_MAX:   prdata[DETA_W-1:0]   = cfg_q.deta_max;
      REG_PAIR_CHECK: prdata[0]            = cfg_q.pair_check_enable;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tomd_eta_store.sv
// eta store of the selected objects with a parallel delta-eta compare
// depends on tomd_pkg
`default_nettype none

module tomd_eta_store #(
  parameter int unsigned MaxObjects = tomd_pkg::MAX_OBJECTS_DEF,
  localparam int unsigned UsedW = $clog2(MaxObjects + 1),
  localparam int unsigned IdxW  = $clog2(MaxObjects)
) (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [UsedW-1:0]                   used_i,
  input  logic signed [tomd_pkg::ETA_W-1:0]  eta_i,
  input  logic [tomd_pkg::DETA_W-1:0]        deta_max_i,
  output logic                               hit_o
);
  import tomd_pkg::*;

  logic [ETA_W-1:0] store_q [MaxObjects];
  logic [ETA_W:0]   diff    [MaxObjects];
  logic [ETA_W:0]   mag     [MaxObjects];

  // write at the current fill position
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[used_i[IdxW-1:0]] <= eta_i;
    end
  end

  // compare the new eta with every filled entry
  always_comb begin
    hit_o = 1'b0;
    for (int k = 0; k < MaxObjects; k++) begin
      diff[k] = {eta_i[ETA_W-1], eta_i} - {store_q[k][ETA_W-1], store_q[k]};
      mag[k]  = diff[k][ETA_W] ? (~diff[k] + 1'b1) : diff[k];
      if ((UsedW'(k) < used_i) && (mag[k][DETA_W-1:0] <= deta_max_i)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/trigger_object_multiplicity_deta_unit.sv
// Trigger object multiplicity unit with delta-eta pair condition.
// Channels: in_i carries one trigger object per transfer (has_object, obj_pt,
//   obj_eta, event_last); out_o carries one result per event (fired,
//   selected_count, stored_overflow), sent after the item marked event_last.
// Configuration: apb port, registers at byte addresses 0,4,8,12,16 for
//   pt_min, eta_max, min_count, deta_max, pair_check_enable.
// Throughput: one item per cycle while out_o takes its results; the eta compare
//   against all stored entries runs combinationally, in parallel.
// Flow: an item is registered in the input register on acceptance and processed
//   from there; the result of a last item is registered in the result register,
//   which drives out_o.
// Stall: while out_o holds an untaken result, non-last items keep flowing;
//   a last item waits in the input register and in_i.ready drops only then.
// Reset: asynchronous, active low; clears the per-event count, pair and
//   overflow flags, the fill count and both valid flags, and loads the
//   register reset values. The eta store itself is not cleared.
// depends on tomd_pkg, tomd_if, tomd_cfg_regs, tomd_eta_store and the assert macros header
`default_nettype none

`include "trigger_object_multiplicity_deta_unit_assert.svh"

module trigger_object_multiplicity_deta_unit #(
  parameter int unsigned MaxObjects = tomd_pkg::MAX_OBJECTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tomd_in_if.sink                         in_i,
  tomd_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tomd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tomd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tomd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tomd_pkg::*;

  localparam int unsigned UsedW = $clog2(MaxObjects + 1);
  localparam logic [UsedW-1:0] MaxUsed = UsedW'(MaxObjects);

  cfg_t cfg;

  // input register
  logic                    s1_valid_q;
  logic                    s1_has_q;
  logic [PT_W-1:0]         s1_pt_q;
  logic signed [ETA_W-1:0] s1_eta_q;
  logic                    s1_last_q;

  // per-event state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pair_q, pair_d;
  logic             ovf_q, ovf_d;
  logic [UsedW-1:0] used_q, used_d;

  // result register
  logic             out_valid_q;
  logic             fired_q;
  logic [CNT_W-1:0] count_q;
  logic             ovf_out_q;

  logic             out_free;
  logic             proc;
  logic             sel;
  logic             sel_fire;
  logic             hit;
  logic             has_room;
  logic [ETA_W-1:0] abs_eta;
  logic             fired_d;
  logic             evt_idle;

  tomd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake: last items wait for a free result slot
  assign out_free   = !out_valid_q || out_o.ready;
  assign proc       = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || proc;

  // object selection
  assign abs_eta  = s1_eta_q[ETA_W-1] ? (~s1_eta_q + 1'b1) : s1_eta_q;
  assign sel      = s1_has_q && (s1_pt_q >= cfg.pt_min) && (abs_eta <= {1'b0, cfg.eta_max});
  assign sel_fire = proc && sel;
  assign has_room = used_q < MaxUsed;

  tomd_eta_store #(
    .MaxObjects (MaxObjects)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (sel_fire && has_room),
    .used_i     (used_q),
    .eta_i      (s1_eta_q),
    .deta_max_i (cfg.deta_max),
    .hit_o      (hit)
  );

  // next event state including the current object
  always_comb begin
    cnt_d  = cnt_q;
    pair_d = pair_q | (sel_fire & hit);
    ovf_d  = ovf_q | (sel_fire & !has_room);
    used_d = used_q;
    if (sel_fire && (cnt_q != CNT_SAT)) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (sel_fire && has_room) begin
      used_d = used_q + 1'b1;
    end
    fired_d = (cnt_d >= cfg.min_count) && (!cfg.pair_check_enable || pair_d);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_has_q  <= in_i.has_object;
      s1_pt_q   <= in_i.obj_pt;
      s1_eta_q  <= in_i.obj_eta;
      s1_last_q <= in_i.event_last;
    end
  end

  // event state, cleared after the last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pair_q <= 1'b0;
      ovf_q  <= 1'b0;
      used_q <= '0;
    end else if (proc && s1_last_q) begin
      cnt_q  <= '0;
      pair_q <= 1'b0;
      ovf_q  <= 1'b0;
      used_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pair_q <= pair_d;
      ovf_q  <= ovf_d;
      used_q <= used_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && s1_last_q) begin
      fired_q   <= fired_d;
      count_q   <= cnt_d;
      ovf_out_q <= ovf_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.fired           = fired_q;
  assign out_o.selected_count  = count_q;
  assign out_o.stored_overflow = ovf_out_q;

  // event state back at its empty value
  assign evt_idle = (cnt_q == '0) && !pair_q && !ovf_q && (used_q == '0);

  // checks
  `TOMD_ASSERT_HOLDS(a_used_bound, clk_i, rst_ni, used_q <= MaxUsed)
  `TOMD_ASSERT_HOLDS(a_ovf_full, clk_i, rst_ni, !ovf_q || (used_q == MaxUsed))
  `TOMD_ASSERT_HOLDS(a_pair_cnt, clk_i, rst_ni, !pair_q || (cnt_q >= PAIR_MIN_CNT))
  `TOMD_ASSERT_NEXT(a_evt_clear, clk_i, rst_ni, proc && s1_last_q, evt_idle)

endmodule

`default_nettype wire

FILE: tb/sv/tb_tomd_event_checker.sv
`timescale 1ns / 100ps
// checker for the trigger object multiplicity unit: follows register writes and
// object transfers, predicts each event result and compares it with the result stream
// depends on tomd_pkg and the tomd_in_if / tomd_out_if interfaces
module tb_tomd_event_checker #(
  parameter int unsigned StoreDepth = tomd_pkg::MAX_OBJECTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tomd_in_if                              obj_mon,
  tomd_out_if                             res_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [tomd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tomd_pkg::APB_DATA_W-1:0] pwdata,
  output int unsigned                     mismatch_total,
  output int unsigned                     results_pending
);
  import tomd_pkg::*;

  typedef struct packed {
    logic             fired;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } event_result_t;

  // event results predicted but not yet seen on the result stream
  event_result_t awaited_results[$];

  // shadow of the registers and of the per-event state
  cfg_t             cfg_shadow;
  int               eta_store[StoreDepth];
  int unsigned      store_used;
  logic [CNT_W-1:0] sel_count;
  logic             pair_seen;
  logic             overflow_seen;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_total < 10) $display("[%0t] %s", $time, msg);
    mismatch_total++;
  endtask

  // stored etas beyond the fill count are never read, so they stay as they are
  task automatic clear_event_state();
    sel_count     = '0;
    pair_seen     = 1'b0;
    overflow_seen = 1'b0;
    store_used    = 0;
  endtask

  task automatic apply_register_write();
    case (reg_idx_e'(paddr[APB_ADDR_W-1:2]))
      REG_PT_MIN:     cfg_shadow.pt_min            = pwdata[PT_W-1:0];
      REG_ETA_MAX:    cfg_shadow.eta_max           = pwdata[ETAMAX_W-1:0];
      REG_MIN_COUNT:  cfg_shadow.min_count         = pwdata[CNT_W-1:0];
      REG_DETA_MAX:   cfg_shadow.deta_max          = pwdata[DETA_W-1:0];
      REG_PAIR_CHECK: cfg_shadow.pair_check_enable = pwdata[0];
      default: ;
    endcase
  endtask

  // selection, pair search against the stored etas, and the result on the last item
  task automatic apply_object(input logic has_obj, input logic [PT_W-1:0] pt,
                              input logic signed [ETA_W-1:0] eta, input logic last);
    int            eta_v;
    event_result_t res;
    eta_v = eta;
    if (has_obj && pt >= cfg_shadow.pt_min && magnitude(eta_v) <= int'(cfg_shadow.eta_max)) begin
      for (int k = 0; k < int'(store_used); k++) begin
        if (magnitude(eta_v - eta_store[k]) <= int'(cfg_shadow.deta_max)) pair_seen = 1'b1;
      end
      if (store_used < StoreDepth) begin
        eta_store[store_used] = eta_v;
        store_used++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (sel_count != CNT_SAT) sel_count++;
    end
    if (last) begin
      res.fired    = (sel_count >= cfg_shadow.min_count) &&
                     (!cfg_shadow.pair_check_enable || pair_seen);
      res.count    = sel_count;
      res.overflow = overflow_seen;
      awaited_results = {awaited_results, res};
      clear_event_state();
    end
  endtask

  task automatic compare_result();
    event_result_t want;
    if (awaited_results.size() == 0) begin
      note_failure($sformatf("result with none awaited: fired %0b count %0d overflow %0b",
                             res_mon.fired, res_mon.selected_count, res_mon.stored_overflow));
    end else begin
      want = awaited_results.pop_front();
      if (res_mon.fired !== want.fired)
        note_failure($sformatf("fired: expected %0b, got %0b", want.fired, res_mon.fired));
      if (res_mon.selected_count !== want.count)
        note_failure($sformatf("selected_count: expected %0d, got %0d",
                               want.count, res_mon.selected_count));
      if (res_mon.stored_overflow !== want.overflow)
        note_failure($sformatf("stored_overflow: expected %0b, got %0b",
                               want.overflow, res_mon.stored_overflow));
    end
  endtask

  // results are checked before the item of the same edge is taken in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_shadow.pt_min            = PT_MIN_RST;
      cfg_shadow.eta_max           = ETA_MAX_RST;
      cfg_shadow.min_count         = MIN_COUNT_RST;
      cfg_shadow.deta_max          = DETA_MAX_RST;
      cfg_shadow.pair_check_enable = 1'b0;
      clear_event_state();
      awaited_results.delete();
      mismatch_total = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) compare_result();
      if (psel && penable && pwrite && pready) apply_register_write();
      if (obj_mon.valid && obj_mon.ready)
        apply_object(obj_mon.has_object, obj_mon.obj_pt, obj_mon.obj_eta, obj_mon.event_last);
    end
    results_pending = awaited_results.size();
  end

endmodule

FILE: tb/sv/tb_trigger_object_multiplicity_deta_unit.sv
`timescale 1ns / 100ps
// testbench top for the trigger object multiplicity unit: clock, reset, register
// writes, object stimulus with random gaps and result stalls, and the verdict
// depends on tomd_pkg, tomd_if, the unit itself and tb_tomd_event_checker
module tb_trigger_object_multiplicity_deta_unit;
  import tomd_pkg::*;

  localparam int unsigned STORE_DEPTH     = MAX_OBJECTS_DEF;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 212;
  localparam int unsigned SETTLE_CYCLES   = 4;
  // index with no register behind it
  localparam logic [2:0]  REG_SPARE       = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;

  int unsigned mismatch_total;
  int unsigned results_pending;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned rx_hold;
  bit          tx_steady;
  bit          rx_steady;

  // current settings, only used to steer the stimulus towards the limits
  int cur_pt_min;
  int cur_eta_max;
  int cur_deta_max;

  tomd_in_if  obj_if ();
  tomd_out_if res_if ();

  trigger_object_multiplicity_deta_unit #(
    .MaxObjects (STORE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (obj_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tb_tomd_event_checker #(
    .StoreDepth (STORE_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .obj_mon         (obj_if),
    .res_mon         (res_if),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_total  (mismatch_total),
    .results_pending (results_pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // watchdog on cycles without any transfer or register access
  always @(posedge clk_i) begin
    if (!rst_ni || (obj_if.valid && obj_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, mostly short, with stretches of none
  initial begin
    res_if.ready = 1'b0;
    rx_steady    = 1'b0;
    rx_hold      = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        res_if.ready = 1'b0;
        rx_hold--;
      end else begin
        res_if.ready = 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0)
          rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
      if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
    end
  end

  // entered and left at a falling edge
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_setting(input int unsigned pt_min, input int unsigned eta_max,
                                 input int unsigned min_count, input int unsigned deta_max,
                                 input int unsigned pair_check);
    write_reg(REG_PT_MIN, pt_min);
    write_reg(REG_ETA_MAX, eta_max);
    write_reg(REG_MIN_COUNT, min_count);
    write_reg(REG_DETA_MAX, deta_max);
    write_reg(REG_PAIR_CHECK, pair_check);
    cur_pt_min   = pt_min;
    cur_eta_max  = eta_max;
    cur_deta_max = deta_max;
  endtask

  // stop sending and let every awaited result arrive
  task automatic settle();
    obj_if.valid = 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one object transfer; valid stays high into the next item when there is no gap
  task automatic send_item(input int has_obj, input int pt, input int eta, input int last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      obj_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    obj_if.has_object = has_obj[0];
    obj_if.obj_pt     = PT_W'(pt);
    obj_if.obj_eta    = ETA_W'(eta);
    obj_if.event_last = last[0];
    obj_if.valid      = 1'b1;
    do @(posedge clk_i); while (!obj_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // momentum mostly around the threshold
  function automatic int pick_pt();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 65535);
      3, 4, 5: v = cur_pt_min + int'($urandom_range(0, 3));
      6, 7:    v = cur_pt_min - int'($urandom_range(1, 3));
      default: v = $urandom_range(0, 1) ? 65535 : cur_pt_min;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // eta clustered around the event's base so that pair distances land near the limit
  function automatic int pick_eta(input int base);
    int v;
    int spread;
    spread = cur_deta_max + 2;
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 2047)) - 1024;
      1, 2: begin
        v = cur_eta_max - 1 + int'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = base + int'($urandom_range(0, 2 * spread)) - spread;
    endcase
    if (v < -1024) v = -1024;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // one event: objects with the odd empty filler, closed by a last object or a bare marker
  task automatic send_random_event();
    int n;
    int base;
    bit last_on_obj;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: n = $urandom_range(0, 6);
      7, 8:                n = $urandom_range(7, 16);
      default:             n = $urandom_range(17, 40);
    endcase
    base        = int'($urandom_range(0, 2 * cur_eta_max)) - cur_eta_max;
    last_on_obj = (n > 0) && ($urandom_range(0, 1) == 1);
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(0, $urandom_range(0, 65535), int'($urandom_range(0, 2047)) - 1024, 0);
      send_item(1, pick_pt(), pick_eta(base), (last_on_obj && i == n - 1) ? 1 : 0);
    end
    if (!last_on_obj) send_item(0, $urandom_range(0, 65535), pick_eta(base), 1);
  endtask

  initial begin
    int unsigned phase_end;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    obj_if.valid      = 1'b0;
    obj_if.has_object = 1'b0;
    obj_if.obj_pt     = '0;
    obj_if.obj_eta    = '0;
    obj_if.event_last = 1'b0;
    tx_steady         = 1'b0;
    items_sent        = 0;
    cur_pt_min        = PT_MIN_RST;
    cur_eta_max       = ETA_MAX_RST;
    cur_deta_max      = DETA_MAX_RST;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: empty event, field extremes, unselectable etas, ignored filler
    send_item(0, 16'h1234, 5, 1);
    send_item(1, 65535, 1000, 1);
    send_item(1, 0, -1000, 0);
    send_item(1, 65535, -1024, 0);
    send_item(1, 65535, 1023, 0);
    send_item(0, 65535, -1, 0);
    send_item(0, 0, 0, 1);
    settle();

    // pair check on: empty selection with zero minimum, pairs at and past the limit
    program_setting(100, 1000, 0, 5, 1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_item(0, 0, 0, 1);
    send_item(1, 99, 0, 0);
    send_item(1, 100, 0, 0);
    send_item(1, 200, 5, 1);
    send_item(1, 300, 0, 0);
    send_item(1, 300, 6, 1);
    send_item(1, 300, -3, 0);
    send_item(1, 300, 2, 1);
    send_item(1, 300, 0, 1);
    settle();

    // tightest cuts: identical etas, count below a minimum of sixteen
    program_setting(65535, 0, 16, 0, 1);
    send_item(1, 65535, 0, 0);
    send_item(1, 65535, 0, 1);
    send_item(1, 65534, 0, 1);
    settle();

    // random phases, each under its own settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: program_setting(0, 1000, 0, 2000, 1);
        1: program_setting(65535, 0, 16, 0, 0);
        2: program_setting($urandom_range(0, 400), 1000, 2, 0, 1);
        default: program_setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 2000),
                                 $urandom_range(0, 1000), $urandom_range(0, 16),
                                 $urandom_range(0, 2000), $urandom_range(0, 1));
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) send_random_event();
      settle();
    end

    repeat (8) @(negedge clk_i);
    if (mismatch_total == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
